// ===== sv/vnsl_pkg.sv =====
// shared constants, codes and types of the voronoi nearest-seed labeler
`default_nettype none

package vnsl_pkg;

    // default sizing of the top level
    localparam int MAX_NODES_DEF  = 1024;
    localparam int MAX_SIDE_DEF   = 256;
    localparam int LABEL_BITS_DEF = 16;

    // fixed field widths
    localparam int COORD_W     = 8;
    localparam int INDEX_W     = 10;
    localparam int IN_LABEL_W  = 16;
    localparam int OUT_LABEL_W = 16;
    localparam int SIDE_W      = 9;
    localparam int COUNT_W     = 11;

    // datapath widths
    localparam int DIFF_W  = COORD_W + 1;        // voxel minus seed, signed
    localparam int SHIFT_W = DIFF_W + 2;         // difference minus side, signed
    localparam int SQ_D_W  = 2 * COORD_W;        // square of a direct difference
    localparam int SQ_E_W  = 20;                 // square of a shifted difference
    localparam int BASE_W  = SQ_D_W + 2;         // sum of three direct squares
    localparam int DIST_W  = 20;                 // any image distance
    localparam int SIDE2_W = 2 * SIDE_W;         // side squared
    localparam int BOUND_W = 2 * SIDE2_W;        // side to the fourth

    // stream and configuration port widths
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 2 * OUT_LABEL_W;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = COUNT_W;

    // input tdata field positions
    localparam int IDX_LSB = 0;
    localparam int X_LSB   = IDX_LSB + INDEX_W;
    localparam int Y_LSB   = X_LSB + COORD_W;
    localparam int Z_LSB   = Y_LSB + COORD_W;
    localparam int LAB_LSB = Z_LSB + COORD_W;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GRID_SIDE  = 1'b0,
        REG_NODE_COUNT = 1'b1
    } cfg_reg_t;

    // item kinds carried in tuser
    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    // token that travels down the cell chain with each node
    typedef struct packed {
        logic vld;
        logic last;
    } tok_t;

endpackage

`default_nettype wire

// ===== sv/voronoi_nearest_seed_labeler.sv =====
// top level of the voronoi nearest-seed labeler: node store, scan control, cell chain
//
// Load transactions (tuser 0) write one seed node into the node store and produce no
// result; the block stays idle, so loads can follow one another without a gap. A query
// transaction (tuser 1) scans nodes 0 to node_count-1 through a chain of cells (store
// read, three axis cells, image cell, best cell), one node per cycle, and returns the
// nearest seed's label together with the running maximum label. A query first forms
// grid_side^4, then scans the nodes at the pace of the single read port of the node
// store, and then lets the last node leave the chain and reach the output register. The
// next transaction is accepted as soon as the result sits in the output register, even
// if it has not been taken yet. The node store has
// no reset; a query must only cover slots loaded since reset.
`default_nettype none

module voronoi_nearest_seed_labeler #(
    parameter int MAX_NODES  = vnsl_pkg::MAX_NODES_DEF,
    parameter int MAX_SIDE   = vnsl_pkg::MAX_SIDE_DEF,
    parameter int LABEL_BITS = vnsl_pkg::LABEL_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // node_index[9:0], coord_x[17:10], coord_y[25:18], coord_z[33:26], seed_label[49:34]
    input  wire logic [vnsl_pkg::IN_DATA_W-1:0]   s_tdata,
    // func[0]
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // cell_label[15:0], max_label[31:16]
    output logic      [vnsl_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  wire logic                             cfg_wr_en,
    input  wire logic [vnsl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [vnsl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import vnsl_pkg::*;

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    typedef struct packed {
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    y;
        logic [COORD_W-1:0]    z;
        logic [LABEL_BITS-1:0] tag;
    } node_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SQ     = 6'b000010,
        ST_QUAD   = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_WAIT   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    // input fields
    logic [INDEX_W-1:0]    in_index;
    logic [COORD_W-1:0]    in_x;
    logic [COORD_W-1:0]    in_y;
    logic [COORD_W-1:0]    in_z;
    logic [IN_LABEL_W-1:0] in_label;
    logic                  in_fire;
    logic                  load_we;
    logic                  query_go;

    // configuration
    logic [SIDE_W-1:0]  grid_side_reg;
    logic [COUNT_W-1:0] node_count_reg;
    logic [SIDE_W-1:0]  side_sat;
    logic [COUNT_W-1:0] cnt_sat;

    // control
    state_t              state_reg;
    state_t              state_next;
    logic [COUNT_W-1:0]  idx_reg;
    logic [COUNT_W-1:0]  idx_next;
    logic                scan_last;
    logic [COORD_W-1:0]  vox_x_reg;
    logic [COORD_W-1:0]  vox_y_reg;
    logic [COORD_W-1:0]  vox_z_reg;
    logic [SIDE2_W-1:0]  side2_reg;
    logic [BOUND_W-1:0]  bound;
    logic                best_init;

    // node store
    node_t mem [MAX_NODES];
    node_t rd_reg;
    tok_t  rd_tok_reg;
    tok_t  rd_tok_next;

    // chain tokens alongside the axis cells
    tok_t                  tok_a_reg;
    tok_t                  tok_b_reg;
    logic [LABEL_BITS-1:0] tag_a_reg;
    logic [LABEL_BITS-1:0] tag_b_reg;

    // cell outputs
    logic [SQ_D_W-1:0]     sqd_x;
    logic [SQ_D_W-1:0]     sqd_y;
    logic [SQ_D_W-1:0]     sqd_z;
    logic [SQ_E_W-1:0]     sqe_x;
    logic [SQ_E_W-1:0]     sqe_y;
    logic [SQ_E_W-1:0]     sqe_z;
    tok_t                  img_tok;
    logic [LABEL_BITS-1:0] img_tag;
    logic [DIST_W-1:0]     img_dist;
    logic [LABEL_BITS-1:0] win_label;
    logic                  scan_done;

    // result and peak
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [LABEL_BITS-1:0] peak_reg;
    logic [LABEL_BITS-1:0] peak_new;
    logic                  out_free;
    logic                  out_load;

    // unpack the input transaction
    assign in_index = s_tdata[IDX_LSB +: INDEX_W];
    assign in_x     = s_tdata[X_LSB +: COORD_W];
    assign in_y     = s_tdata[Y_LSB +: COORD_W];
    assign in_z     = s_tdata[Z_LSB +: COORD_W];
    assign in_label = s_tdata[LAB_LSB +: IN_LABEL_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign load_we  = in_fire && (s_tuser == FUNC_LOAD) && (32'(in_index) < MAX_NODES);
    assign query_go = in_fire && (s_tuser == FUNC_QUERY);

    // saturate the registers to the built sizes
    assign side_sat = (32'(grid_side_reg) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : grid_side_reg;
    assign cnt_sat  = (32'(node_count_reg) > MAX_NODES) ? COUNT_W'(MAX_NODES) : node_count_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg  <= SIDE_W'(256);
            node_count_reg <= COUNT_W'(1);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_GRID_SIDE:  grid_side_reg  <= cfg_wdata[SIDE_W-1:0];
                REG_NODE_COUNT: node_count_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // scan sequencer
    assign scan_last = (idx_reg == cnt_sat - COUNT_W'(1));
    assign out_free  = !out_valid_reg || m_tready;
    assign best_init = (state_reg == ST_QUAD);
    assign bound     = side2_reg * side2_reg;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        rd_tok_next = '0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_go)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                state_next = ST_QUAD;
            end
            ST_QUAD:
            begin
                idx_next   = '0;
                state_next = (cnt_sat == '0) ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN:
            begin
                rd_tok_next.vld  = 1'b1;
                rd_tok_next.last = scan_last;
                idx_next         = idx_reg + COUNT_W'(1);
                if (scan_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            rd_tok_reg <= '0;
            tok_a_reg  <= '0;
            tok_b_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            rd_tok_reg <= rd_tok_next;
            tok_a_reg  <= rd_tok_reg;
            tok_b_reg  <= tok_a_reg;
        end
    end

    // query operands
    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            vox_x_reg <= in_x;
            vox_y_reg <= in_y;
            vox_z_reg <= in_z;
        end
        side2_reg <= side_sat * side_sat;
        tag_a_reg <= rd_reg.tag;
        tag_b_reg <= tag_a_reg;
    end

    // node store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            mem[AW'(in_index)] <= '{x: in_x, y: in_y, z: in_z, tag: LABEL_BITS'(in_label)};
        end
        rd_reg <= mem[AW'(idx_reg)];
    end

    // axis cells
    vnsl_axis u_axis_x (
        .clk       (clk),
        .vox       (vox_x_reg),
        .seed      (rd_reg.x),
        .side      (side_sat),
        .sq_direct (sqd_x),
        .sq_shift  (sqe_x)
    );

    vnsl_axis u_axis_y (
        .clk       (clk),
        .vox       (vox_y_reg),
        .seed      (rd_reg.y),
        .side      (side_sat),
        .sq_direct (sqd_y),
        .sq_shift  (sqe_y)
    );

    vnsl_axis u_axis_z (
        .clk       (clk),
        .vox       (vox_z_reg),
        .seed      (rd_reg.z),
        .side      (side_sat),
        .sq_direct (sqd_z),
        .sq_shift  (sqe_z)
    );

    // image selection cell
    vnsl_image #(
        .LABEL_BITS (LABEL_BITS)
    ) u_image (
        .clk     (clk),
        .rst_n   (rst_n),
        .tok_in  (tok_b_reg),
        .tag_in  (tag_b_reg),
        .sqd_x   (sqd_x),
        .sqd_y   (sqd_y),
        .sqd_z   (sqd_z),
        .sqe_x   (sqe_x),
        .sqe_y   (sqe_y),
        .sqe_z   (sqe_z),
        .tok_out (img_tok),
        .tag_out (img_tag),
        .sq_dist (img_dist)
    );

    // running minimum cell
    vnsl_best #(
        .LABEL_BITS (LABEL_BITS)
    ) u_best (
        .clk     (clk),
        .rst_n   (rst_n),
        .init    (best_init),
        .bound   (bound),
        .tok_in  (img_tok),
        .tag_in  (img_tag),
        .sq_dist (img_dist),
        .label   (win_label),
        .done    (scan_done)
    );

    // peak label and output register
    assign peak_new = (win_label > peak_reg) ? win_label : peak_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            peak_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (out_load)
            begin
                peak_reg <= peak_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {OUT_LABEL_W'(peak_new), OUT_LABEL_W'(win_label)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== sv/vnsl_axis.sv =====
// per-axis cell: difference, shifted difference and their squares over two stages
`default_nettype none

module vnsl_axis (
    input  wire logic                         clk,
    input  wire logic [vnsl_pkg::COORD_W-1:0] vox,
    input  wire logic [vnsl_pkg::COORD_W-1:0] seed,
    input  wire logic [vnsl_pkg::SIDE_W-1:0]  side,
    output logic      [vnsl_pkg::SQ_D_W-1:0]  sq_direct,
    output logic      [vnsl_pkg::SQ_E_W-1:0]  sq_shift
);
    import vnsl_pkg::*;

    logic signed [DIFF_W-1:0]    diff_reg;
    logic signed [DIFF_W-1:0]    diff_next;
    logic signed [SHIFT_W-1:0]   shift_reg;
    logic signed [SHIFT_W-1:0]   shift_next;
    logic signed [2*DIFF_W-1:0]  prod_d;
    logic signed [2*SHIFT_W-1:0] prod_e;
    logic [SQ_D_W-1:0]           sq_direct_reg;
    logic [SQ_E_W-1:0]           sq_shift_reg;

    // direct and periodic-image differences
    always_comb
    begin
        diff_next  = $signed({1'b0, vox}) - $signed({1'b0, seed});
        shift_next = SHIFT_W'(diff_next) - $signed({2'b00, side});
    end

    // squares of both differences
    always_comb
    begin
        prod_d = diff_reg * diff_reg;
        prod_e = shift_reg * shift_reg;
    end

    always_ff @(posedge clk)
    begin
        diff_reg      <= diff_next;
        shift_reg     <= shift_next;
        sq_direct_reg <= prod_d[SQ_D_W-1:0];
        sq_shift_reg  <= prod_e[SQ_E_W-1:0];
    end

    assign sq_direct = sq_direct_reg;
    assign sq_shift  = sq_shift_reg;

endmodule

`default_nettype wire

// ===== sv/vnsl_image.sv =====
// image cell: sums the squares and picks the first shifted image that is closer
`default_nettype none

module vnsl_image #(
    parameter int LABEL_BITS = vnsl_pkg::LABEL_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire vnsl_pkg::tok_t              tok_in,
    input  wire logic [LABEL_BITS-1:0]       tag_in,
    input  wire logic [vnsl_pkg::SQ_D_W-1:0] sqd_x,
    input  wire logic [vnsl_pkg::SQ_D_W-1:0] sqd_y,
    input  wire logic [vnsl_pkg::SQ_D_W-1:0] sqd_z,
    input  wire logic [vnsl_pkg::SQ_E_W-1:0] sqe_x,
    input  wire logic [vnsl_pkg::SQ_E_W-1:0] sqe_y,
    input  wire logic [vnsl_pkg::SQ_E_W-1:0] sqe_z,
    output vnsl_pkg::tok_t                   tok_out,
    output logic      [LABEL_BITS-1:0]       tag_out,
    output logic      [vnsl_pkg::DIST_W-1:0] sq_dist
);
    import vnsl_pkg::*;

    tok_t                  tok_c_reg;
    logic [LABEL_BITS-1:0] tag_c_reg;
    logic [BASE_W-1:0]     base_reg;
    logic [BASE_W-1:0]     base_next;
    logic [DIST_W-1:0]     tx_reg;
    logic [DIST_W-1:0]     tx_next;
    logic [DIST_W-1:0]     ty_reg;
    logic [DIST_W-1:0]     ty_next;
    logic [DIST_W-1:0]     tz_reg;
    logic [DIST_W-1:0]     tz_next;
    logic [DIST_W-1:0]     base_ext;
    tok_t                  tok_d_reg;
    logic [LABEL_BITS-1:0] tag_d_reg;
    logic [DIST_W-1:0]     dist_reg;
    logic [DIST_W-1:0]     dist_next;

    // direct distance and the three single-axis images
    always_comb
    begin
        base_next = BASE_W'(sqd_x) + BASE_W'(sqd_y) + BASE_W'(sqd_z);
        tx_next   = DIST_W'(sqe_x) + DIST_W'(sqd_y) + DIST_W'(sqd_z);
        ty_next   = DIST_W'(sqd_x) + DIST_W'(sqe_y) + DIST_W'(sqd_z);
        tz_next   = DIST_W'(sqd_x) + DIST_W'(sqd_y) + DIST_W'(sqe_z);
    end

    // x image first, then y, then z; only the first closer one counts
    always_comb
    begin
        base_ext = DIST_W'(base_reg);
        if (tx_reg < base_ext)
        begin
            dist_next = tx_reg;
        end
        else if (ty_reg < base_ext)
        begin
            dist_next = ty_reg;
        end
        else if (tz_reg < base_ext)
        begin
            dist_next = tz_reg;
        end
        else
        begin
            dist_next = base_ext;
        end
    end

    // token flow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_c_reg <= '0;
            tok_d_reg <= '0;
        end
        else
        begin
            tok_c_reg <= tok_in;
            tok_d_reg <= tok_c_reg;
        end
    end

    // payload flow
    always_ff @(posedge clk)
    begin
        tag_c_reg <= tag_in;
        base_reg  <= base_next;
        tx_reg    <= tx_next;
        ty_reg    <= ty_next;
        tz_reg    <= tz_next;
        tag_d_reg <= tag_c_reg;
        dist_reg  <= dist_next;
    end

    assign tok_out = tok_d_reg;
    assign tag_out = tag_d_reg;
    assign sq_dist = dist_reg;

endmodule

`default_nettype wire

// ===== sv/vnsl_best.sv =====
// best cell: keeps the smallest distance seen and the label that goes with it
`default_nettype none

module vnsl_best #(
    parameter int LABEL_BITS = vnsl_pkg::LABEL_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         init,
    input  wire logic [vnsl_pkg::BOUND_W-1:0] bound,
    input  wire vnsl_pkg::tok_t               tok_in,
    input  wire logic [LABEL_BITS-1:0]        tag_in,
    input  wire logic [vnsl_pkg::DIST_W-1:0]  sq_dist,
    output logic      [LABEL_BITS-1:0]        label,
    output logic                              done
);
    import vnsl_pkg::*;

    logic [BOUND_W-1:0]    best_reg;
    logic [LABEL_BITS-1:0] label_reg;
    logic                  done_reg;
    logic                  closer;

    // strictly closer keeps the earlier node on a tie
    assign closer = BOUND_W'(sq_dist) < best_reg;

    // end-of-scan flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !init && tok_in.vld && tok_in.last;
        end
    end

    // running minimum
    always_ff @(posedge clk)
    begin
        if (init)
        begin
            best_reg  <= bound;
            label_reg <= '0;
        end
        else if (tok_in.vld && closer)
        begin
            best_reg  <= BOUND_W'(sq_dist);
            label_reg <= tag_in;
        end
    end

    assign label = label_reg;
    assign done  = done_reg;

endmodule

`default_nettype wire

// ===== sv/vnsl_checker.sv =====
// port-level checks of the voronoi nearest-seed labeler and their bind
`default_nettype none

module vnsl_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             s_tuser,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [vnsl_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import vnsl_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // the peak label is never below the label it accompanies
    a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:16] >= m_tdata[15:0])
        else $error("max_label below cell_label");

    // an accepted query closes the input
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == FUNC_QUERY) |=> !s_tready)
        else $error("input open right after a query");

    // a new result only appears at the end of a query
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result without a running query");

endmodule

bind voronoi_nearest_seed_labeler vnsl_checker u_vnsl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
